/* src/ocm_pkg.sv */
// Shared types, constants and the plan-to-cost table for the cost merge block.
`timescale 1ns / 1ps
`default_nettype none
package ocm_pkg;

  localparam int COORD_W     = 12;
  localparam int COST_W      = 8;
  localparam int GRID_W_BITS = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int COORD_LIMIT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'd1;

  localparam logic [COST_W-1:0] COST_FREE      = 8'd0;
  localparam logic [COST_W-1:0] COST_INSCRIBED = 8'd253;
  localparam logic [COST_W-1:0] COST_LETHAL    = 8'd254;
  localparam logic [COST_W-1:0] COST_UNKNOWN   = 8'd255;

  localparam int XLATE_SCALE = 251;
  localparam int XLATE_DIV   = 97;
  localparam int PLAN_INSCR  = 99;
  localparam int PLAN_FULL   = 100;

  typedef logic [127:0][COST_W-1:0] xlate_lut_t;

  typedef struct packed {
    logic [COST_W-1:0] new_cost;
    logic              written;
    logic              occupied;
    logic              merged;
  } merge_res_t;

  typedef struct packed {
    logic               box_valid;
    logic [COORD_W-1:0] min_col;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] max_col;
    logic [COORD_W-1:0] max_row;
    logic               frame_empty;
  } summary_t;

  // Occupancy percent to cost; values above full scale map like full scale.
  function automatic xlate_lut_t build_xlate_lut();
    xlate_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      if (i == 0) lut[i] = COST_FREE;
      else if (i >= PLAN_FULL) lut[i] = COST_LETHAL;
      else if (i == PLAN_INSCR) lut[i] = COST_INSCRIBED;
      else lut[i] = COST_W'(1 + (XLATE_SCALE * (i - 1)) / XLATE_DIV);
    end
    return lut;
  endfunction

  localparam xlate_lut_t XLATE_LUT = build_xlate_lut();

endpackage
`default_nettype wire

/* src/ocm_if.sv */
// Valid/ready channel interfaces for grid cell items and merged result items.
`timescale 1ns / 1ps
`default_nettype none
interface ocm_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] plan_cost;
  logic [7:0]        master_cost;
  logic              last_cell;

  modport source (output valid, plan_cost, master_cost, last_cell, input ready);
  modport sink   (input valid, plan_cost, master_cost, last_cell, output ready);
endinterface

interface ocm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  new_cost;
  logic        cost_written;
  logic        frame_done;
  logic        box_valid;
  logic [11:0] box_min_col;
  logic [11:0] box_min_row;
  logic [11:0] box_max_col;
  logic [11:0] box_max_row;
  logic        frame_empty;

  modport source (output valid, new_cost, cost_written, frame_done, box_valid,
                  box_min_col, box_min_row, box_max_col, box_max_row, frame_empty,
                  input ready);
  modport sink   (input valid, new_cost, cost_written, frame_done, box_valid,
                  box_min_col, box_min_row, box_max_col, box_max_row, frame_empty,
                  output ready);
endinterface
`default_nettype wire

/* src/ocm_merge.sv */
// Per-cell cost translation and merge into the master cost.
`timescale 1ns / 1ps
`default_nettype none
module ocm_merge (
  input  wire logic                       enable,
  input  wire logic signed [7:0]          plan_cost,
  input  wire logic [ocm_pkg::COST_W-1:0] master_cost,
  output ocm_pkg::merge_res_t             res
);
  import ocm_pkg::*;

  logic [COST_W-1:0] xlate;
  logic [COST_W:0]   sum;

  assign xlate = XLATE_LUT[plan_cost[6:0]];
  assign sum   = {1'b0, master_cost} + {1'b0, xlate};

  always_comb begin
    res.new_cost = master_cost;
    res.written  = 1'b0;
    res.occupied = 1'b0;
    res.merged   = 1'b0;
    if (enable) begin
      if (plan_cost[7]) begin
        res.new_cost = COST_UNKNOWN;
        res.written  = 1'b1;
      end else if (plan_cost[6:0] != 7'd0) begin
        res.occupied = 1'b1;
        // Inscribed and lethal master cells are not overwritten by an occupied plan cell.
        if (master_cost != COST_INSCRIBED && master_cost != COST_LETHAL) begin
          res.new_cost = (sum > {1'b0, COST_INSCRIBED}) ? COST_INSCRIBED : sum[COST_W-1:0];
          res.written  = 1'b1;
          res.merged   = 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* src/ocm_tracker.sv */
// Raster position counter and per-frame bounding box / merge flag tracker.
`timescale 1ns / 1ps
`default_nettype none
module ocm_tracker #(
  parameter int ROW_LIMIT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            advance,
  input  wire logic                            last_cell,
  input  wire logic                            occupied,
  input  wire logic                            merged,
  input  wire logic [ocm_pkg::GRID_W_BITS-1:0] row_width,
  output ocm_pkg::summary_t                    summary
);
  import ocm_pkg::*;

  localparam logic [GRID_W_BITS-1:0] ROW_LIM = GRID_W_BITS'(ROW_LIMIT);

  logic [COORD_W-1:0] col_r, row_r, min_col_r, min_row_r, max_col_r, max_row_r;
  logic               seen_r, merged_r;
  logic [COORD_W-1:0] min_col_nxt, min_row_nxt, max_col_nxt, max_row_nxt;
  logic               seen_nxt, merged_nxt;
  logic [GRID_W_BITS-1:0] col_inc, row_inc;

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;

  always_comb begin
    min_col_nxt = (occupied && col_r < min_col_r) ? col_r : min_col_r;
    min_row_nxt = (occupied && row_r < min_row_r) ? row_r : min_row_r;
    max_col_nxt = (occupied && col_r > max_col_r) ? col_r : max_col_r;
    max_row_nxt = (occupied && row_r > max_row_r) ? row_r : max_row_r;
    seen_nxt    = seen_r | occupied;
    merged_nxt  = merged_r | merged;
  end

  always_comb begin
    summary.box_valid   = seen_nxt;
    summary.min_col     = min_col_nxt;
    summary.min_row     = min_row_nxt;
    summary.max_col     = max_col_nxt;
    summary.max_row     = max_row_nxt;
    summary.frame_empty = ~merged_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_cell)) begin
      col_r     <= '0;
      row_r     <= '0;
      min_col_r <= '1;
      min_row_r <= '1;
      max_col_r <= '0;
      max_row_r <= '0;
      seen_r    <= 1'b0;
      merged_r  <= 1'b0;
    end else if (advance) begin
      min_col_r <= min_col_nxt;
      min_row_r <= min_row_nxt;
      max_col_r <= max_col_nxt;
      max_row_r <= max_row_nxt;
      seen_r    <= seen_nxt;
      merged_r  <= merged_nxt;
      // A column past the row width (width changed mid-frame) also wraps.
      if (col_inc >= row_width) begin
        col_r <= '0;
        row_r <= (row_inc >= ROW_LIM) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_r <= col_inc[COORD_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

/* src/occupancy_cost_merge_top.sv */
// Cost merge block: a cell item enters an input register, is merged, and
// lands in a result register, which it enters once that register is free or
// its result is taken; one item is accepted per cycle while results are taken,
// set by the single merge stage between the two registers.
// Reset (rst_n low at a clock edge) empties both stages, restores enable = 1
// and width 4096, and clears position, box and merge flag; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_cost_merge_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ocm_in_if.sink                              in_ch,
  ocm_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ocm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ocm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ocm_pkg::*;

  localparam int WIDTH_CAP  = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
  localparam int HEIGHT_CAP = (MAX_HEIGHT < COORD_LIMIT) ? MAX_HEIGHT : COORD_LIMIT;
  localparam logic [GRID_W_BITS-1:0] WIDTH_LIM = GRID_W_BITS'(WIDTH_CAP);

  logic                   enable_r;
  logic [GRID_W_BITS-1:0] grid_width_r;
  logic [GRID_W_BITS-1:0] row_width;

  logic              s1_valid_r;
  logic signed [7:0] s1_plan_r;
  logic [COST_W-1:0] s1_master_r;
  logic              s1_last_r;

  logic       out_valid_r;
  logic       out_free, advance;
  merge_res_t mres;
  summary_t   summ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      grid_width_r <= GRID_W_BITS'(COORD_LIMIT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:     enable_r     <= cfg_wdata[0];
        REG_GRID_WIDTH: grid_width_r <= cfg_wdata[GRID_W_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    if (grid_width_r == '0) row_width = GRID_W_BITS'(1);
    else if (grid_width_r > WIDTH_LIM) row_width = WIDTH_LIM;
    else row_width = grid_width_r;
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_plan_r   <= in_ch.plan_cost;
      s1_master_r <= in_ch.master_cost;
      s1_last_r   <= in_ch.last_cell;
    end
  end

  ocm_merge u_merge (
    .enable      (enable_r),
    .plan_cost   (s1_plan_r),
    .master_cost (s1_master_r),
    .res         (mres)
  );

  ocm_tracker #(
    .ROW_LIMIT (HEIGHT_CAP)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .last_cell (s1_last_r),
    .occupied  (mres.occupied),
    .merged    (mres.merged),
    .row_width (row_width),
    .summary   (summ)
  );

  // Summary fields only carry meaning on the frame's last cell.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.new_cost     <= mres.new_cost;
      out_ch.cost_written <= mres.written;
      out_ch.frame_done   <= s1_last_r;
      out_ch.box_valid    <= s1_last_r && summ.box_valid;
      out_ch.box_min_col  <= (s1_last_r && summ.box_valid) ? summ.min_col : '0;
      out_ch.box_min_row  <= (s1_last_r && summ.box_valid) ? summ.min_row : '0;
      out_ch.box_max_col  <= (s1_last_r && summ.box_valid) ? summ.max_col : '0;
      out_ch.box_max_row  <= (s1_last_r && summ.box_valid) ? summ.max_row : '0;
      out_ch.frame_empty  <= s1_last_r && summ.frame_empty;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_summary_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.frame_done |->
      !out_ch.box_valid && !out_ch.frame_empty && out_ch.box_min_col == '0
      && out_ch.box_max_row == '0)
    else $error("summary fields set on a non-final item");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.box_valid |->
      out_ch.box_min_col <= out_ch.box_max_col && out_ch.box_min_row <= out_ch.box_max_row)
    else $error("bounding box minimum exceeds maximum");

  a_written_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.cost_written |->
      out_ch.new_cost <= COST_INSCRIBED || out_ch.new_cost == COST_UNKNOWN)
    else $error("written cost outside merge range");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("merged item did not reach the result register");
endmodule
`default_nettype wire

/* sim/ocm_merge_check.sv */
// Channel monitor for the cost merge block: predicts every merged cell and compares it.
`timescale 1ns / 1ps
module ocm_merge_check #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ocm_in_if                              in_ch,
  ocm_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [ocm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ocm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_owed
);
  import ocm_pkg::*;

  localparam int WIDTH_CAP  = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
  localparam int HEIGHT_CAP = (MAX_HEIGHT < COORD_LIMIT) ? MAX_HEIGHT : COORD_LIMIT;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [COST_W-1:0]  new_cost;
    logic               written;
    logic               frame_done;
    logic               box_valid;
    logic [COORD_W-1:0] min_col;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] max_col;
    logic [COORD_W-1:0] max_row;
    logic               frame_empty;
  } cell_result_t;

  logic                   enable_q;
  logic [GRID_W_BITS-1:0] grid_width_q;
  logic [COORD_W-1:0]     col_pos, row_pos;
  logic [COORD_W-1:0]     seen_min_col, seen_min_row, seen_max_col, seen_max_row;
  logic                   occupied_seen, merged_seen;
  int unsigned            err_total = 0;

  cell_result_t pending_costs[$];

  function automatic int occupancy_to_cost(int pct);
    if (pct == 0) return 0;
    if (pct >= PLAN_FULL) return int'(COST_LETHAL);
    if (pct == PLAN_INSCR) return int'(COST_INSCRIBED);
    return 1 + (XLATE_SCALE * (pct - 1)) / XLATE_DIV;
  endfunction

  function automatic void clear_frame();
    col_pos       = '0;
    row_pos       = '0;
    seen_min_col  = '1;
    seen_min_row  = '1;
    seen_max_col  = '0;
    seen_max_row  = '0;
    occupied_seen = 1'b0;
    merged_seen   = 1'b0;
  endfunction

  // Merges one cell into the master cost and advances the raster position.
  function automatic cell_result_t merge_cell(logic signed [7:0] plan, logic [7:0] master,
                                              logic last);
    cell_result_t r;
    int           w;
    int           sum;
    r = '0;
    w = int'(grid_width_q);
    if (w == 0) w = 1;
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    r.new_cost = master;
    if (enable_q) begin
      if (plan < 0) begin
        r.new_cost = COST_UNKNOWN;
        r.written  = 1'b1;
      end else if (plan != 0) begin
        if (col_pos < seen_min_col) seen_min_col = col_pos;
        if (row_pos < seen_min_row) seen_min_row = row_pos;
        if (col_pos > seen_max_col) seen_max_col = col_pos;
        if (row_pos > seen_max_row) seen_max_row = row_pos;
        occupied_seen = 1'b1;
        if (master != COST_INSCRIBED && master != COST_LETHAL) begin
          sum = int'(master) + occupancy_to_cost(int'(plan));
          r.new_cost  = (sum > int'(COST_INSCRIBED)) ? COST_INSCRIBED : COST_W'(sum);
          r.written   = 1'b1;
          merged_seen = 1'b1;
        end
      end
    end
    if (last) begin
      r.frame_done  = 1'b1;
      r.box_valid   = occupied_seen;
      r.frame_empty = !merged_seen;
      if (occupied_seen) begin
        r.min_col = seen_min_col;
        r.min_row = seen_min_row;
        r.max_col = seen_max_col;
        r.max_row = seen_max_row;
      end
      clear_frame();
    end else if (int'(col_pos) + 1 >= w) begin
      // A column past the width (width lowered mid-frame) also ends the row here.
      col_pos = '0;
      row_pos = (int'(row_pos) + 1 >= HEIGHT_CAP) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (err_total < PRINT_CAP)
      $display("%0t ocm_merge_check: %s: got %0d, want %0d", $time, what, got, want);
    err_total++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) flag_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst_n) begin
      enable_q     = 1'b1;
      grid_width_q = GRID_W_BITS'(COORD_LIMIT);
      clear_frame();
      pending_costs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:     enable_q = cfg_wdata[0];
          REG_GRID_WIDTH: grid_width_q = cfg_wdata[GRID_W_BITS-1:0];
          default: ;
        endcase
      end
      // Results are checked before this edge's cell is queued, so a result can
      // never be matched against the item accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        got.new_cost    = out_ch.new_cost;
        got.written     = out_ch.cost_written;
        got.frame_done  = out_ch.frame_done;
        got.box_valid   = out_ch.box_valid;
        got.min_col     = out_ch.box_min_col;
        got.min_row     = out_ch.box_min_row;
        got.max_col     = out_ch.box_max_col;
        got.max_row     = out_ch.box_max_row;
        got.frame_empty = out_ch.frame_empty;
        if (pending_costs.size() == 0) begin
          flag_mismatch("result item with nothing expected", int'(got.new_cost), -1);
        end else begin
          want = pending_costs.pop_front();
          check_field("new_cost", int'(got.new_cost), int'(want.new_cost));
          check_field("cost_written", int'(got.written), int'(want.written));
          check_field("frame_done", int'(got.frame_done), int'(want.frame_done));
          check_field("box_valid", int'(got.box_valid), int'(want.box_valid));
          check_field("box_min_col", int'(got.min_col), int'(want.min_col));
          check_field("box_min_row", int'(got.min_row), int'(want.min_row));
          check_field("box_max_col", int'(got.max_col), int'(want.max_col));
          check_field("box_max_row", int'(got.max_row), int'(want.max_row));
          check_field("frame_empty", int'(got.frame_empty), int'(want.frame_empty));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_costs.push_back(merge_cell(in_ch.plan_cost, in_ch.master_cost,
                                           in_ch.last_cell));
    end
    mismatch_count <= err_total;
    results_owed   <= pending_costs.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top: drives cell items and register writes into the cost merge block.
`timescale 1ns / 1ps
module tb_top;
  import ocm_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatch_count;
  int unsigned           results_owed;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;

  ocm_in_if  in_ch ();
  ocm_out_if out_ch ();

  occupancy_cost_merge_top #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ocm_merge_check #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one cell item, after a random gap, and returns at the edge that takes it.
  task automatic send_cell(input logic signed [7:0] plan, input logic [7:0] master,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.plan_cost <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.plan_cost   <= plan;
    in_ch.master_cost <= master;
    in_ch.last_cell   <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [7:0] pick_plan();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'sd0;
    if (r < 30) return -8'sd1;
    if (r < 37) return 8'($urandom_range(128, 255));
    if (r < 85) return 8'($urandom_range(1, 100));
    return 8'($urandom_range(101, 127));
  endfunction

  function automatic logic [7:0] pick_master();
    int r;
    r = $urandom_range(99);
    if (r < 12) return COST_FREE;
    if (r < 30) begin
      case ($urandom_range(3))
        0:       return COST_INSCRIBED - 8'd1;
        1:       return COST_INSCRIBED;
        2:       return COST_LETHAL;
        default: return COST_UNKNOWN;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Short random frames in segments, each segment under a fresh register setting.
  task automatic run_random(input int n_items);
    int   sent;
    int   seg_left;
    int   frame_len;
    int   r;
    logic en;
    logic lst;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      en = ($urandom_range(99) < 85);
      write_reg(REG_ENABLE, {12'($urandom_range(0, 4095)), en});
      r = $urandom_range(99);
      if (r < 20) write_reg(REG_GRID_WIDTH, 13'd1);
      else if (r < 30) write_reg(REG_GRID_WIDTH, 13'd2);
      else if (r < 60) write_reg(REG_GRID_WIDTH, 13'($urandom_range(3, 12)));
      else if (r < 68) write_reg(REG_GRID_WIDTH, 13'd0);
      else if (r < 78) write_reg(REG_GRID_WIDTH, 13'(COORD_LIMIT));
      else if (r < 88) write_reg(REG_GRID_WIDTH, 13'($urandom_range(4097, 8191)));
      else write_reg(REG_GRID_WIDTH, 13'($urandom_range(13, 64)));
      seg_left = $urandom_range(50, 90);
      while (seg_left > 0) begin
        frame_len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        for (int k = 0; k < frame_len; k++) begin
          // Now and then a frame is cut short by an early last cell.
          lst = (k == frame_len - 1) || ($urandom_range(49) == 0);
          send_cell(pick_plan(), pick_master(), lst);
        end
        seg_left -= frame_len;
        sent     += frame_len;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.plan_cost   = 8'sd0;
    in_ch.master_cost = 8'd0;
    in_ch.last_cell   = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_ENABLE;
    cfg_wdata         = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Translation and merge corners under the reset setting.
    send_cell(8'sd0, 8'd17, 1'b0);
    send_cell(-8'sd1, 8'd40, 1'b0);
    send_cell(8'h80, 8'd0, 1'b0);
    send_cell(8'sd1, 8'd0, 1'b0);
    send_cell(8'sd98, 8'd2, 1'b0);
    send_cell(8'sd99, 8'd0, 1'b0);
    send_cell(8'sd100, 8'd0, 1'b0);
    send_cell(8'sd127, 8'd1, 1'b0);
    send_cell(8'sd50, COST_INSCRIBED, 1'b0);
    send_cell(8'sd50, COST_LETHAL, 1'b0);
    send_cell(8'sd10, COST_UNKNOWN, 1'b0);
    send_cell(8'sd0, COST_UNKNOWN, 1'b1);

    // The width drops below the current column in the middle of a frame.
    wait_idle();
    write_reg(REG_GRID_WIDTH, 13'd8);
    for (int k = 0; k < 6; k++) send_cell(8'sd0, 8'($urandom_range(0, 255)), 1'b0);
    send_cell(8'sd33, 8'd5, 1'b0);
    wait_idle();
    write_reg(REG_GRID_WIDTH, 13'd3);
    send_cell(8'sd5, 8'd100, 1'b0);
    send_cell(8'sd7, 8'd9, 1'b1);

    // Disabled: costs pass through and the frame reports nothing seen.
    wait_idle();
    write_reg(REG_ENABLE, 13'd0);
    send_cell(-8'sd1, 8'd77, 1'b0);
    send_cell(8'sd60, 8'd3, 1'b1);

    wait_idle();
    write_reg(REG_ENABLE, 13'd1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      run_random(320);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* files.f */
src/ocm_pkg.sv
src/ocm_if.sv
src/ocm_merge.sv
src/ocm_tracker.sv
src/occupancy_cost_merge_top.sv
sim/ocm_merge_check.sv
sim/tb_top.sv
